// File: rtl/yuv420_geometric_remap_addresser_core_macros.svh
// Assertion macros for the 4:2:0 remap addresser.
// Clocked on aclk, disabled while aresetn is low; included by the top level.
`ifndef YUV420_GEOMETRIC_REMAP_ADDRESSER_CORE_MACROS_SVH
`define YUV420_GEOMETRIC_REMAP_ADDRESSER_CORE_MACROS_SVH

// Same-cycle implication.
`define YGA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("remap addresser: same-cycle check failed");

// Next-cycle implication.
`define YGA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("remap addresser: next-cycle check failed");

`endif

// File: rtl/yga_pkg.sv
// Shared types and constants for the 4:2:0 remap addresser.
// Used by yga_seed, yga_coord and the top level; depends on nothing.
package yga_pkg;

    localparam logic [11:0] MAX_WIDTH  = 12'd2048;
    localparam logic [11:0] MAX_HEIGHT = 12'd2048;
    localparam int          TILE_LOG2  = 4;
    localparam int          TILE_SIZE  = 1 << TILE_LOG2;
    localparam int          TILE_HALF  = TILE_SIZE / 2;

    // Signed coordinate width: covers -2048..2055 with margin.
    localparam int CW = 13;
    typedef logic signed [CW-1:0] coord_t;

    typedef enum logic [2:0] {
        MODE_IDENTITY = 3'd0,
        MODE_HMIRROR  = 3'd1,
        MODE_VFLIP    = 3'd2,
        MODE_BOTH     = 3'd3,
        MODE_JITTER   = 3'd4,
        MODE_TILES    = 3'd5
    } mode_t;

    localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_TRANSFORM_MODE = 2'd2;

    localparam logic [11:0] RESET_WIDTH  = 12'd320;
    localparam logic [11:0] RESET_HEIGHT = 12'd240;

    // LCG step and its compositions: seed_k = A_k * seed + C_k (mod 2^32).
    localparam logic [31:0] LCG_A1 = 32'd1103515245;
    localparam logic [31:0] LCG_C1 = 32'd12345;
    localparam logic [31:0] LCG_A2 = 32'(LCG_A1 * LCG_A1);
    localparam logic [31:0] LCG_C2 = 32'(LCG_A1 * LCG_C1 + LCG_C1);
    localparam logic [31:0] LCG_A3 = 32'(LCG_A1 * LCG_A2);
    localparam logic [31:0] LCG_C3 = 32'(LCG_A1 * LCG_C2 + LCG_C1);
    localparam logic [31:0] LCG_A4 = 32'(LCG_A1 * LCG_A3);
    localparam logic [31:0] LCG_C4 = 32'(LCG_A1 * LCG_C3 + LCG_C1);

    // Four 2-bit draws in the order they are consumed.
    typedef struct packed {
        logic [1:0] luma_row;
        logic [1:0] luma_col;
        logic [1:0] chroma_row;
        logic [1:0] chroma_col;
    } draw_t;

    // Effective frame geometry.
    typedef struct packed {
        logic [11:0] w;
        logic [11:0] h;
        logic [10:0] hw;
        logic [10:0] hh;
    } geom_t;

    // Remapped source position: luma = lx + ly*w,
    // chroma = cx + cy*hw, or cx + (cy*w)>>2 when quarter is set.
    typedef struct packed {
        coord_t lx;
        coord_t ly;
        coord_t cx;
        coord_t cy;
        logic   quarter;
    } remap_t;

endpackage

// File: rtl/yga_seed.sv
// Jitter seed register: advances four LCG steps per jitter pixel at once.
// Depends on yga_pkg for the composed LCG constants and draw_t.
module yga_seed (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    output yga_pkg::draw_t draws
);
    import yga_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] seed_next;
    logic [31:0] seed1, seed2, seed3;

    // Each step is a constant multiply of the held seed; no chaining.
    assign seed1     = 32'(LCG_A1 * seed_reg + LCG_C1);
    assign seed2     = 32'(LCG_A2 * seed_reg + LCG_C2);
    assign seed3     = 32'(LCG_A3 * seed_reg + LCG_C3);
    assign seed_next = 32'(LCG_A4 * seed_reg + LCG_C4);

    assign draws.luma_row   = seed1[31:30];
    assign draws.luma_col   = seed2[31:30];
    assign draws.chroma_row = seed3[31:30];
    assign draws.chroma_col = seed_next[31:30];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (advance) begin
            seed_reg <= seed_next;
        end
    end

endmodule

// File: rtl/yga_coord.sv
// Per-mode coordinate mapping for the remap addresser (combinational).
// Depends on yga_pkg for mode_t, geom_t, draw_t and remap_t.
module yga_coord (
    input  logic [10:0]     column,
    input  logic [10:0]     row,
    input  yga_pkg::draw_t  draws,
    input  yga_pkg::mode_t  mode,
    input  yga_pkg::geom_t  geom,
    output yga_pkg::remap_t remap
);
    import yga_pkg::*;

    // Fold within a tile, then clamp to 0..lim-1.
    function automatic coord_t tile_fold(logic [10:0] p, logic [11:0] lim);
        logic signed [13:0] base;
        logic signed [13:0] dt;
        logic signed [13:0] t;
        logic signed [13:0] slim;
        base = $signed({3'b0, p});
        dt   = $signed(14'(p[TILE_LOG2-1:0])) - 14'(TILE_HALF);
        slim = $signed({2'b0, lim});
        t    = p[TILE_LOG2] ? base - dt : base + dt;
        if (t < 0) begin
            t = '0;
        end else if (t >= slim) begin
            t = slim - 14'sd1;
        end
        return $signed(t[CW-1:0]);
    endfunction

    // Jittered position: p + draw - 2.
    function automatic coord_t jitter(logic [10:0] p, logic [1:0] dd);
        coord_t t;
        t = $signed({2'b0, p}) + $signed({11'b0, dd}) - coord_t'(2);
        return t;
    endfunction

    coord_t px, py, ws, hs, hws, hhs;
    coord_t mx, my;
    coord_t jlx, jly, jcx, jcy;
    coord_t tx, ty;

    always_comb begin
        px  = $signed({2'b0, column});
        py  = $signed({2'b0, row});
        ws  = $signed({1'b0, geom.w});
        hs  = $signed({1'b0, geom.h});
        hws = $signed({2'b0, geom.hw});
        hhs = $signed({2'b0, geom.hh});
        mx  = ws - coord_t'(1) - px;
        my  = hs - coord_t'(1) - py;

        // Step a jittered column that lands beyond w back by one.
        jly = jitter(row, draws.luma_row);
        jlx = jitter(column, draws.luma_col);
        if (jlx > ws) begin
            jlx = jlx - coord_t'(1);
        end
        jcy = jitter(row, draws.chroma_row);
        jcx = jitter(column, draws.chroma_col);
        if (jcx > ws) begin
            jcx = jcx - coord_t'(1);
        end

        ty = tile_fold(row, geom.h);
        tx = tile_fold(column, geom.w);

        remap.quarter = 1'b0;
        unique case (mode)
            MODE_HMIRROR: begin
                remap.lx = mx;
                remap.ly = py;
                remap.cx = hws - coord_t'(1) - (px >>> 1);
                remap.cy = py >>> 1;
            end
            MODE_VFLIP: begin
                remap.lx = px;
                remap.ly = my;
                remap.cx = px >>> 1;
                remap.cy = hhs - coord_t'(1) - (py >>> 1);
            end
            MODE_BOTH: begin
                remap.lx = mx;
                remap.ly = my;
                remap.cx = mx >>> 1;
                remap.cy = my >>> 1;
            end
            MODE_JITTER: begin
                remap.lx = jlx;
                remap.ly = jly;
                remap.cx = jcx >>> 1;
                remap.cy = jcy >>> 1;
            end
            MODE_TILES: begin
                remap.lx = tx;
                remap.ly = ty;
                remap.cx = tx >>> 1;
                remap.cy = ty >>> 1;
            end
            default: begin
                // identity: chroma row term is (row * w) >> 2
                remap.lx      = px;
                remap.ly      = py;
                remap.cx      = px >>> 1;
                remap.cy      = py;
                remap.quarter = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/yuv420_geometric_remap_addresser_core.sv
// YUV 4:2:0 geometric remap address generator, top level.
// Depends on yga_pkg, yga_seed, yga_coord and the assertion macro header.
//
// Takes output pixel coordinates and returns the source luma offset and the
// source chroma offset (shared by both chroma planes) for one of six remaps:
// identity, horizontal mirror, vertical flip, both, random jitter and
// square-tile mirroring. The block accepts one pixel per clock unless the
// output stalls and returns one result per pixel. Four register stages
// carry each pixel: input capture, mode mapping, the multiply by the line
// pitch, and the plane range check with the chroma hold. The jitter seed
// advances by four LCG steps per jitter pixel through four parallel constant
// multiplies, so it never limits the rate. Offsets outside their plane read
// as zero. Outside jitter mode the chroma offset is refreshed only at pixels
// with even column and row and repeats in between. Frame size and mode are
// to be written through the cfg port only while no pixel is in flight; the
// block itself does not enforce this. The derived geometry is registered
// from the stored frame size. Nothing needs a clearing pass after reset.
module yuv420_geometric_remap_addresser_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    // pixel coordinate input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [10:0] column, [21:11] row, [23:22] zero
    // remapped offset output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [21:0] luma_offset, [41:22] chroma_offset, zero
    output logic [0:0]  m_tuser    // [0] chroma_strobe
);
    import yga_pkg::*;

    `include "yuv420_geometric_remap_addresser_core_macros.svh"

    localparam logic [10:0] RESET_HW    = RESET_WIDTH[11:1];
    localparam logic [10:0] RESET_HH    = RESET_HEIGHT[11:1];
    localparam logic [22:0] RESET_WH    = 23'(23'(RESET_WIDTH) * 23'(RESET_HEIGHT));
    localparam logic [20:0] RESET_CSIZE = 21'(21'(RESET_HW) * 21'(RESET_HH));

    // ---------------- configuration ----------------
    logic [11:0] frame_width_reg;
    logic [11:0] frame_height_reg;
    mode_t       mode_reg;
    geom_t       geom_reg, geom_next;
    logic [22:0] wh_reg, wh_next;
    logic [20:0] csize_reg, csize_next;
    logic [11:0] w_even, h_even;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RESET_WIDTH;
            frame_height_reg <= RESET_HEIGHT;
            mode_reg         <= MODE_IDENTITY;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_TRANSFORM_MODE: begin
                    // drop writes of the two unused mode codes
                    if (cfg_data[2:0] <= MODE_TILES) begin
                        mode_reg <= mode_t'(cfg_data[2:0]);
                    end
                end
                default: ;
            endcase
        end
    end

    // Clear bit 0 and clamp to 2..MAX; register the plane sizes.
    always_comb begin
        w_even = {frame_width_reg[11:1], 1'b0};
        h_even = {frame_height_reg[11:1], 1'b0};
        if (w_even < 12'd2) begin
            geom_next.w = 12'd2;
        end else if (w_even > MAX_WIDTH) begin
            geom_next.w = MAX_WIDTH;
        end else begin
            geom_next.w = w_even;
        end
        if (h_even < 12'd2) begin
            geom_next.h = 12'd2;
        end else if (h_even > MAX_HEIGHT) begin
            geom_next.h = MAX_HEIGHT;
        end else begin
            geom_next.h = h_even;
        end
        geom_next.hw = geom_next.w[11:1];
        geom_next.hh = geom_next.h[11:1];
        wh_next      = 23'(24'(geom_next.w) * 24'(geom_next.h));
        csize_next   = 21'(22'(geom_next.hw) * 22'(geom_next.hh));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geom_reg  <= '{w: RESET_WIDTH, h: RESET_HEIGHT, hw: RESET_HW, hh: RESET_HH};
            wh_reg    <= RESET_WH;
            csize_reg <= RESET_CSIZE;
        end else begin
            geom_reg  <= geom_next;
            wh_reg    <= wh_next;
            csize_reg <= csize_next;
        end
    end

    // ---------------- pipeline handshake ----------------
    logic in_valid_reg, mid_valid_reg, prod_valid_reg, m_tvalid_reg;
    logic out_ready, prod_ready, mid_ready, in_ready;
    logic s_fire, prod_fire;

    assign out_ready  = !m_tvalid_reg || m_tready;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign mid_ready  = !mid_valid_reg || prod_ready;
    assign in_ready   = !in_valid_reg || mid_ready;
    assign s_tready   = in_ready;
    assign s_fire     = s_tvalid && in_ready;
    assign prod_fire  = prod_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            mid_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_tvalid;
            end
            if (mid_ready) begin
                mid_valid_reg <= in_valid_reg;
            end
            if (prod_ready) begin
                prod_valid_reg <= mid_valid_reg;
            end
            if (out_ready) begin
                m_tvalid_reg <= prod_valid_reg;
            end
        end
    end

    // ---------------- stage 0: capture coordinates and draws ----------------
    draw_t       draws;
    logic [10:0] in_col_reg, in_row_reg;
    draw_t       in_draw_reg;

    // Advance the seed only for transfers taken in jitter mode.
    yga_seed u_seed (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (s_fire && (mode_reg == MODE_JITTER)),
        .draws   (draws)
    );

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_col_reg  <= s_tdata[10:0];
            in_row_reg  <= s_tdata[21:11];
            in_draw_reg <= draws;
        end
    end

    // ---------------- stage 1: mode mapping ----------------
    remap_t remap;
    remap_t mid_reg;
    logic   mid_strobe_reg;

    yga_coord u_coord (
        .column (in_col_reg),
        .row    (in_row_reg),
        .draws  (in_draw_reg),
        .mode   (mode_reg),
        .geom   (geom_reg),
        .remap  (remap)
    );

    always_ff @(posedge aclk) begin
        if (in_valid_reg && mid_ready) begin
            mid_reg        <= remap;
            mid_strobe_reg <= !in_col_reg[0] && !in_row_reg[0];
        end
    end

    // ---------------- stage 2: multiply by pitch ----------------
    logic signed [25:0] luma_prod, chroma_prod, chroma_term;
    logic [11:0]        chroma_pitch;
    logic signed [25:0] prod_luma_reg, prod_chroma_reg;
    logic               prod_strobe_reg;

    always_comb begin
        luma_prod    = 26'(mid_reg.ly) * 26'($signed({1'b0, geom_reg.w}));
        chroma_pitch = mid_reg.quarter ? geom_reg.w : {1'b0, geom_reg.hw};
        chroma_prod  = 26'(mid_reg.cy) * 26'($signed({1'b0, chroma_pitch}));
        chroma_term  = mid_reg.quarter ? (chroma_prod >>> 2) : chroma_prod;
    end

    always_ff @(posedge aclk) begin
        if (mid_valid_reg && prod_ready) begin
            prod_luma_reg   <= 26'(mid_reg.lx) + luma_prod;
            prod_chroma_reg <= 26'(mid_reg.cx) + chroma_term;
            prod_strobe_reg <= mid_strobe_reg;
        end
    end

    // ---------------- stage 3: range check and chroma hold ----------------
    logic [19:0] held_reg, held_next;
    logic [19:0] chroma_checked;
    logic        luma_ok, chroma_ok;
    logic [47:0] m_tdata_reg;
    logic        m_tuser_reg;

    always_comb begin
        luma_ok   = (prod_luma_reg >= 0) && (prod_luma_reg < $signed({3'b0, wh_reg}));
        chroma_ok = (prod_chroma_reg >= 0) && (prod_chroma_reg < $signed({5'b0, csize_reg}));
        chroma_checked = chroma_ok ? prod_chroma_reg[19:0] : '0;
        // Reload the hold at strobe pixels, or at every pixel in jitter mode.
        if (prod_strobe_reg || (mode_reg == MODE_JITTER)) begin
            held_next = chroma_checked;
        end else begin
            held_next = held_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (prod_fire) begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_fire) begin
            m_tdata_reg <= luma_ok ? {6'b0, held_next, prod_luma_reg[21:0]} : '0;
            m_tuser_reg <= prod_strobe_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // ---------------- assertions ----------------
    // A stalled input means every stage is full behind a stalled output.
    `YGA_ASSERT_IMPL(a_stall_source, !s_tready, m_tvalid && !m_tready)
    // Offsets delivered stay inside their planes. A repeated chroma offset
    // may come from an earlier frame size, so check chroma where it reloads.
    `YGA_ASSERT_IMPL(a_luma_range, m_tvalid, {1'b0, m_tdata[21:0]} < wh_reg)
    `YGA_ASSERT_IMPL(a_chroma_range, m_tvalid && m_tuser[0], {1'b0, m_tdata[41:22]} < csize_reg)
    // Outside jitter mode a non-strobe pixel leaves the chroma hold alone.
    `YGA_ASSERT_NEXT(a_hold_keep,
        prod_fire && !prod_strobe_reg && (mode_reg != MODE_JITTER), $stable(held_reg))

endmodule
